// File: hw/rtl/tdma_st_pkg.sv
// Package for the TDMA slot table with aging.
// Holds field widths, command and status codes, and the control/status structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tdma_st_pkg;

    // Default table depth and the reset value of the idle timeout register.
    localparam int SLOT_COUNT_DEF = 10;
    localparam int TIMEOUT_W      = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    // Field widths of one input item and one result item.
    localparam int CMD_W    = 2;
    localparam int NODE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int MASK_W   = 10;
    localparam int COUNT_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_JOIN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ASSIGNED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SWEPT     = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input item and restart the scan
        logic issue;   // read the table entry at the scan address and advance
        logic finish;  // form the result and write the table back
    } tdma_st_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;       // captured item needs no table scan
        logic last_addr;  // scan address points at the last entry
    } tdma_st_stat_t;

endpackage

// File: hw/rtl/tdma_st_ctrl.sv
// Controller state machine of the TDMA slot table.
// Sequences load, table scan, drain and finish; drives busy and the done strobe.
// Depends on tdma_st_pkg.
`timescale 1ns / 1ps

module tdma_st_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tdma_st_pkg::tdma_st_stat_t stat,
    output tdma_st_pkg::tdma_st_ctl_t  ctl,
    output logic                       busy,
    output logic                       done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.skip)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.issue = 1'b1;
                    if (stat.last_addr)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // The last entry read is evaluated in this cycle.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: hw/rtl/tdma_st_dp.sv
// Datapath of the TDMA slot table: owner and last-seen memories, valid bits,
// scan address, match/free trackers, sweep aging, timeout register and result registers.
// Depends on tdma_st_pkg.
`timescale 1ns / 1ps

module tdma_st_dp
#(
    parameter int SLOT_COUNT = tdma_st_pkg::SLOT_COUNT_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tdma_st_pkg::tdma_st_ctl_t              ctl,
    output tdma_st_pkg::tdma_st_stat_t             stat,
    input  logic [tdma_st_pkg::CMD_W-1:0]          command,
    input  logic [tdma_st_pkg::NODE_W-1:0]         node_id,
    input  logic [tdma_st_pkg::TIME_W-1:0]         now_sec,
    input  logic                                   cfg_wr_en,
    input  logic [tdma_st_pkg::TIMEOUT_W-1:0]      cfg_wr_data,
    output logic [tdma_st_pkg::STATUS_W-1:0]       status,
    output logic [tdma_st_pkg::SLOT_W-1:0]         slot_number,
    output logic [tdma_st_pkg::MASK_W-1:0]         freed_mask,
    output logic [tdma_st_pkg::COUNT_W-1:0]        freed_count
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // Table storage; an entry without its valid bit reads as a free slot.
    logic [tdma_st_pkg::NODE_W-1:0] owner_mem_reg [SLOT_COUNT];
    logic [tdma_st_pkg::TIME_W-1:0] seen_mem_reg  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]          valid_reg;
    logic [SLOT_COUNT-1:0]          valid_next;

    // Captured item and configuration.
    logic [tdma_st_pkg::CMD_W-1:0]     cmd_reg;
    logic [tdma_st_pkg::NODE_W-1:0]    node_reg;
    logic [tdma_st_pkg::TIME_W-1:0]    now_reg;
    logic [tdma_st_pkg::TIMEOUT_W-1:0] timeout_reg;

    // Scan pipeline.
    logic [IDX_W-1:0]               addr_reg;
    logic                           eval_vld_reg;
    logic [IDX_W-1:0]               eval_idx_reg;
    logic [tdma_st_pkg::NODE_W-1:0] rd_owner_reg;
    logic [tdma_st_pkg::TIME_W-1:0] rd_seen_reg;
    logic                           rd_valid_reg;

    // Scan trackers.
    logic                            match_found_reg, match_found_next;
    logic [IDX_W-1:0]                match_idx_reg, match_idx_next;
    logic                            free_found_reg, free_found_next;
    logic [IDX_W-1:0]                free_idx_reg, free_idx_next;
    logic [tdma_st_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [tdma_st_pkg::COUNT_W-1:0] count_reg, count_next;

    // Result registers.
    logic [tdma_st_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tdma_st_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [tdma_st_pkg::MASK_W-1:0]   res_mask_reg, res_mask_next;
    logic [tdma_st_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;

    // Write-back controls.
    logic                           owner_we;
    logic                           seen_we;
    logic [IDX_W-1:0]               wr_idx;
    logic [tdma_st_pkg::NODE_W-1:0] owner_eff;
    logic [tdma_st_pkg::TIME_W-1:0] age;
    logic                           is_sweep;
    logic                           expired;
    logic [IDX_W:0]                 slot_one_based;

    // An item with an unused command, or a join or refresh from node zero, is invalid.
    assign is_sweep = (cmd_reg == tdma_st_pkg::CMD_SWEEP);
    assign stat.skip = !is_sweep &&
                       (((cmd_reg != tdma_st_pkg::CMD_JOIN) &&
                         (cmd_reg != tdma_st_pkg::CMD_REFRESH)) ||
                        (node_reg == '0));
    assign stat.last_addr = (addr_reg == LAST_IDX);

    // Aging test on the entry just read, with wrapping subtraction.
    assign owner_eff = rd_valid_reg ? rd_owner_reg : '0;
    assign age       = now_reg - rd_seen_reg;
    assign expired   = (owner_eff != '0) &&
                       (age > {{(tdma_st_pkg::TIME_W - tdma_st_pkg::TIMEOUT_W){1'b0}},
                               timeout_reg});

    // Evaluate the entry read in the previous cycle.
    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        mask_next        = mask_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        if (ctl.load)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            mask_next        = '0;
            count_next       = '0;
        end
        else if (eval_vld_reg)
        begin
            if (is_sweep)
            begin
                if (expired)
                begin
                    valid_next[eval_idx_reg] = 1'b0;
                    if (eval_idx_reg < tdma_st_pkg::MASK_W)
                    begin
                        mask_next = mask_reg | (tdma_st_pkg::MASK_W'(1) << eval_idx_reg);
                    end
                    if (count_reg != tdma_st_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (!match_found_reg && (owner_eff == node_reg))
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = eval_idx_reg;
                end
                if (!free_found_reg && (owner_eff == '0))
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = eval_idx_reg;
                end
            end
        end

        // Set the valid bit of a newly assigned slot.
        if (owner_we)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    // Result and write-back at the end of an item.
    assign wr_idx         = match_found_reg ? match_idx_reg : free_idx_reg;
    assign slot_one_based = {1'b0, wr_idx} + 1'b1;

    always_comb
    begin
        status_next    = status_reg;
        slot_next      = slot_reg;
        res_mask_next  = res_mask_reg;
        res_count_next = res_count_reg;
        owner_we       = 1'b0;
        seen_we        = 1'b0;
        if (ctl.finish)
        begin
            slot_next      = '0;
            res_mask_next  = '0;
            res_count_next = '0;
            if (stat.skip)
            begin
                status_next = tdma_st_pkg::ST_INVALID;
            end
            else if (is_sweep)
            begin
                status_next    = tdma_st_pkg::ST_SWEPT;
                res_mask_next  = mask_reg;
                res_count_next = count_reg;
            end
            else if (match_found_reg)
            begin
                seen_we     = 1'b1;
                slot_next   = tdma_st_pkg::SLOT_W'(slot_one_based);
                status_next = (cmd_reg == tdma_st_pkg::CMD_JOIN) ?
                              tdma_st_pkg::ST_KEPT : tdma_st_pkg::ST_REFRESHED;
            end
            else if (cmd_reg == tdma_st_pkg::CMD_REFRESH)
            begin
                status_next = tdma_st_pkg::ST_NOT_FOUND;
            end
            else if (free_found_reg)
            begin
                owner_we    = 1'b1;
                seen_we     = 1'b1;
                slot_next   = tdma_st_pkg::SLOT_W'(slot_one_based);
                status_next = tdma_st_pkg::ST_ASSIGNED;
            end
            else
            begin
                status_next = tdma_st_pkg::ST_FULL;
            end
        end
    end

    // Control state: valid bits, scan address, pipeline flag, trackers, timeout.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            addr_reg        <= '0;
            eval_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            timeout_reg     <= tdma_st_pkg::TIMEOUT_RESET;
        end
        else
        begin
            valid_reg       <= valid_next;
            eval_vld_reg    <= ctl.issue;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            if (ctl.load)
            begin
                addr_reg <= '0;
            end
            else if (ctl.issue && !stat.last_addr)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            node_reg <= node_id;
            now_reg  <= now_sec;
        end
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        mask_reg      <= mask_next;
        count_reg     <= count_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        res_mask_reg  <= res_mask_next;
        res_count_reg <= res_count_next;
    end

    // Table memories: one registered read and one write per cycle each.
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            rd_owner_reg <= owner_mem_reg[addr_reg];
            rd_seen_reg  <= seen_mem_reg[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
            eval_idx_reg <= addr_reg;
        end
        if (owner_we)
        begin
            owner_mem_reg[wr_idx] <= node_reg;
        end
        if (seen_we)
        begin
            seen_mem_reg[wr_idx] <= now_reg;
        end
    end

    assign status      = status_reg;
    assign slot_number = slot_reg;
    assign freed_mask  = res_mask_reg;
    assign freed_count = res_count_reg;

endmodule

// File: hw/rtl/tdma_slot_table_with_aging.sv
// Top level of the TDMA slot table with aging.
// Instantiates tdma_st_ctrl and tdma_st_dp; depends on tdma_st_pkg.
`timescale 1ns / 1ps

// An item (join, refresh or sweep) is taken when start is high while busy is low.
// Its result appears on status, slot_number, freed_mask and freed_count for exactly
// one cycle with done high; the receiver cannot stall, so it must capture the result
// in that cycle. A valid item walks the table through its single read port, one entry
// per cycle, then passes a drain state and a finish state before done rises; busy
// falls in the done cycle, so a new item can be taken while done is high. An invalid
// item (unused command, or node id zero on a join or refresh) skips both the walk
// and the drain state and goes straight to the finish state.
// Write idle_timeout_sec through cfg_wr_en and cfg_wr_data only while no item is
// in flight.
module tdma_slot_table_with_aging
#(
    parameter int SLOT_COUNT = tdma_st_pkg::SLOT_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tdma_st_pkg::CMD_W-1:0]       command,
    input  logic [tdma_st_pkg::NODE_W-1:0]      node_id,
    input  logic [tdma_st_pkg::TIME_W-1:0]      now_sec,
    output logic                                done,
    output logic [tdma_st_pkg::STATUS_W-1:0]    status,
    output logic [tdma_st_pkg::SLOT_W-1:0]      slot_number,
    output logic [tdma_st_pkg::MASK_W-1:0]      freed_mask,
    output logic [tdma_st_pkg::COUNT_W-1:0]     freed_count,
    input  logic                                cfg_wr_en,
    input  logic [tdma_st_pkg::TIMEOUT_W-1:0]   cfg_wr_data
);

    tdma_st_pkg::tdma_st_ctl_t  ctl;
    tdma_st_pkg::tdma_st_stat_t stat;

    // Sequencer.
    tdma_st_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // Table, trackers and result registers.
    tdma_st_dp
    #(
        .SLOT_COUNT (SLOT_COUNT)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .node_id     (node_id),
        .now_sec     (now_sec),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .slot_number (slot_number),
        .freed_mask  (freed_mask),
        .freed_count (freed_count)
    );

endmodule

// File: hw/rtl/tdma_st_chk.sv
// Port-level checker for the TDMA slot table, bound to the top level.
// Depends on tdma_st_pkg and tdma_slot_table_with_aging.
`timescale 1ns / 1ps

module tdma_st_chk
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [tdma_st_pkg::STATUS_W-1:0]    status,
    input logic [tdma_st_pkg::SLOT_W-1:0]      slot_number,
    input logic [tdma_st_pkg::MASK_W-1:0]      freed_mask,
    input logic [tdma_st_pkg::COUNT_W-1:0]     freed_count
);

    // An accepted item keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result only follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done strobe without an item in flight");

    // The done strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    // Only a sweep reports freed slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != tdma_st_pkg::ST_SWEPT)) |->
            ((freed_mask == '0) && (freed_count == '0)))
        else $error("freed slots reported outside a sweep");

    // Results that name no slot carry slot number zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == tdma_st_pkg::ST_FULL) ||
                  (status == tdma_st_pkg::ST_NOT_FOUND) ||
                  (status == tdma_st_pkg::ST_INVALID) ||
                  (status == tdma_st_pkg::ST_SWEPT))) |-> (slot_number == '0))
        else $error("slot number set on a result without a slot");

endmodule

bind tdma_slot_table_with_aging tdma_st_chk u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .slot_number (slot_number),
    .freed_mask  (freed_mask),
    .freed_count (freed_count)
);

// File: test/tb_top.sv
// Self-checking testbench for the TDMA slot table with aging.
// Drives join, refresh and sweep items and checks every result against a predictor
// kept in a small scoreboard class. Depends on tdma_st_pkg and tdma_slot_table_with_aging.
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS = tdma_st_pkg::SLOT_COUNT_DEF;
    localparam logic [tdma_st_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    // Wait after a drain: the walk of a valid item, with a margin on top.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 267;

    typedef struct packed {
        logic [tdma_st_pkg::STATUS_W-1:0] status;
        logic [tdma_st_pkg::SLOT_W-1:0]   slot;
        logic [tdma_st_pkg::MASK_W-1:0]   mask;
        logic [tdma_st_pkg::COUNT_W-1:0]  count;
    } slot_answer_t;

    // Scoreboard: predicts the answer of each accepted item and checks the results.
    class slot_table_checker;
        logic [tdma_st_pkg::NODE_W-1:0]    owner_of [SLOTS];
        logic [tdma_st_pkg::TIME_W-1:0]    seen_at [SLOTS];
        logic [tdma_st_pkg::TIMEOUT_W-1:0] idle_limit;
        slot_answer_t                      pending_answers [$];
        int                                errors;

        function new();
            foreach (owner_of[i])
            begin
                owner_of[i] = '0;
                seen_at[i] = '0;
            end
            idle_limit = tdma_st_pkg::TIMEOUT_RESET;
            errors = 0;
        endfunction

        // Lowest slot whose owner equals the given id, or -1.
        function int find_slot(logic [tdma_st_pkg::NODE_W-1:0] node);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (owner_of[i] == node)
                    return i;
            end
            return -1;
        endfunction

        function void note_item(logic [tdma_st_pkg::CMD_W-1:0] cmd,
                                logic [tdma_st_pkg::NODE_W-1:0] node,
                                logic [tdma_st_pkg::TIME_W-1:0] now);
            slot_answer_t                   ans;
            logic [tdma_st_pkg::TIME_W-1:0] idle_for;
            int                             hit;
            ans = '0;
            ans.status = tdma_st_pkg::ST_INVALID;
            if (cmd == tdma_st_pkg::CMD_SWEEP)
            begin
                // Free every occupied slot idle for longer than the limit.
                for (int i = 0; i < SLOTS; i++)
                begin
                    idle_for = now - seen_at[i];
                    if (owner_of[i] != '0 &&
                        idle_for > tdma_st_pkg::TIME_W'(idle_limit))
                    begin
                        owner_of[i] = '0;
                        seen_at[i] = '0;
                        if (i < tdma_st_pkg::MASK_W)
                            ans.mask[i] = 1'b1;
                        if (ans.count != tdma_st_pkg::COUNT_MAX)
                            ans.count = ans.count + 1'b1;
                    end
                end
                ans.status = tdma_st_pkg::ST_SWEPT;
            end
            else if ((cmd == tdma_st_pkg::CMD_JOIN || cmd == tdma_st_pkg::CMD_REFRESH) &&
                     node != '0)
            begin
                hit = find_slot(node);
                if (hit >= 0)
                begin
                    seen_at[hit] = now;
                    ans.status = (cmd == tdma_st_pkg::CMD_JOIN) ?
                                 tdma_st_pkg::ST_KEPT : tdma_st_pkg::ST_REFRESHED;
                    ans.slot = tdma_st_pkg::SLOT_W'(hit + 1);
                end
                else if (cmd == tdma_st_pkg::CMD_REFRESH)
                begin
                    ans.status = tdma_st_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    // New node: take the lowest free slot if there is one.
                    hit = find_slot('0);
                    if (hit >= 0)
                    begin
                        owner_of[hit] = node;
                        seen_at[hit] = now;
                        ans.status = tdma_st_pkg::ST_ASSIGNED;
                        ans.slot = tdma_st_pkg::SLOT_W'(hit + 1);
                    end
                    else
                    begin
                        ans.status = tdma_st_pkg::ST_FULL;
                    end
                end
            end
            pending_answers.push_back(ans);
        endfunction

        function void mismatch(string field, int want, int got);
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
        endfunction

        function void check_result(slot_answer_t got);
            slot_answer_t want;
            if (pending_answers.size() == 0)
            begin
                $error("result with no item pending: status %0d", got.status);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status)
                mismatch("status", want.status, got.status);
            if (got.slot !== want.slot)
                mismatch("slot_number", want.slot, got.slot);
            if (got.mask !== want.mask)
                mismatch("freed_mask", want.mask, got.mask);
            if (got.count !== want.count)
                mismatch("freed_count", want.count, got.count);
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [tdma_st_pkg::CMD_W-1:0]     command;
    logic [tdma_st_pkg::NODE_W-1:0]    node_id;
    logic [tdma_st_pkg::TIME_W-1:0]    now_sec;
    logic                              done;
    logic [tdma_st_pkg::STATUS_W-1:0]  status;
    logic [tdma_st_pkg::SLOT_W-1:0]    slot_number;
    logic [tdma_st_pkg::MASK_W-1:0]    freed_mask;
    logic [tdma_st_pkg::COUNT_W-1:0]   freed_count;
    logic                              cfg_wr_en;
    logic [tdma_st_pkg::TIMEOUT_W-1:0] cfg_wr_data;

    slot_table_checker              table_model = new();
    int                             idle_pct;
    int                             stall_cycles;
    logic [tdma_st_pkg::TIME_W-1:0] clock_sec;
    logic [tdma_st_pkg::NODE_W-1:0] node_pool [14] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                                                       8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
                                                       8'd12, 8'd128, 8'd255};

    tdma_slot_table_with_aging dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .node_id     (node_id),
        .now_sec     (now_sec),
        .done        (done),
        .status      (status),
        .slot_number (slot_number),
        .freed_mask  (freed_mask),
        .freed_count (freed_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
            table_model.check_result({status, slot_number, freed_mask, freed_count});
    end

    // Watchdog: ends the run when no item has been accepted and no result has come back for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item, with random idle cycles first, and hold it until it is taken.
    task automatic send_item(input logic [tdma_st_pkg::CMD_W-1:0] cmd,
                             input logic [tdma_st_pkg::NODE_W-1:0] node,
                             input logic [tdma_st_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        node_id <= node;
        now_sec <= now;
        do
            @(posedge clk);
        while (busy);
        table_model.note_item(cmd, node, now);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        while (table_model.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [tdma_st_pkg::TIMEOUT_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        table_model.idle_limit = value;
    endtask

    // One random item: mostly joins and refreshes from a small node pool so the
    // table fills up, sweeps at times near the aging boundary, and some noise.
    task automatic random_item(input int tmo);
        int                             pick;
        int                             s;
        logic [tdma_st_pkg::CMD_W-1:0]  cmd;
        logic [tdma_st_pkg::NODE_W-1:0] node;
        pick = $urandom_range(99);
        if (pick < 50)
            clock_sec = clock_sec + $urandom_range(0, 3);
        else if (pick < 80)
            clock_sec = clock_sec + $urandom_range(0, 2 * tmo + 2);
        else if (pick < 92)
        begin
            s = $urandom_range(0, SLOTS - 1);
            clock_sec = table_model.seen_at[s] + tmo + $urandom_range(0, 1);
        end
        else
            clock_sec = $urandom;

        if ($urandom_range(9) == 0)
            node = tdma_st_pkg::NODE_W'($urandom_range(1, 255));
        else
            node = node_pool[$urandom_range(0, 13)];

        pick = $urandom_range(99);
        if (pick < 45)
            cmd = tdma_st_pkg::CMD_JOIN;
        else if (pick < 68)
            cmd = tdma_st_pkg::CMD_REFRESH;
        else if (pick < 88)
        begin
            cmd = tdma_st_pkg::CMD_SWEEP;
            node = tdma_st_pkg::NODE_W'($urandom_range(0, 255));
        end
        else if (pick < 93)
        begin
            cmd = CMD_UNUSED;
            node = tdma_st_pkg::NODE_W'($urandom_range(0, 255));
        end
        else
        begin
            cmd = $urandom_range(1) ? tdma_st_pkg::CMD_JOIN : tdma_st_pkg::CMD_REFRESH;
            node = '0;
        end
        send_item(cmd, node, clock_sec);
    endtask

    initial
    begin
        int tmo_set [PHASES];
        int idle_set [PHASES];
        tmo_set = '{0, 65535, 5, 0, 100, 1};
        idle_set = '{0, 80, 38, 0, 80, 38};
        tmo_set[3] = $urandom_range(2, 65534);

        rst_n <= 1'b0;
        start <= 1'b0;
        command <= tdma_st_pkg::CMD_JOIN;
        node_id <= '0;
        now_sec <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        idle_pct = 0;
        clock_sec = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset timeout: invalid items, fill, full, boundary sweep.
        send_item(tdma_st_pkg::CMD_JOIN, 8'd0, 32'h0000_0000);
        send_item(tdma_st_pkg::CMD_REFRESH, 8'd0, 32'hFFFF_FFFF);
        send_item(CMD_UNUSED, 8'd255, 32'd5);
        send_item(CMD_UNUSED, 8'd0, 32'd0);
        send_item(tdma_st_pkg::CMD_REFRESH, 8'd7, 32'd10);
        send_item(tdma_st_pkg::CMD_SWEEP, 8'd0, 32'd0);
        send_item(tdma_st_pkg::CMD_JOIN, 8'd255, 32'd0);
        for (int i = 1; i < SLOTS; i++)
            send_item(tdma_st_pkg::CMD_JOIN, 8'(i), 32'(i));
        send_item(tdma_st_pkg::CMD_JOIN, 8'd128, 32'd20);
        send_item(tdma_st_pkg::CMD_JOIN, 8'd255, 32'd20);
        send_item(tdma_st_pkg::CMD_REFRESH, 8'd9, 32'hFFFF_FFFF);
        // Slot seen at 8 is exactly at the limit and stays; the one seen at 7 goes.
        send_item(tdma_st_pkg::CMD_SWEEP, 8'd0, 32'd38);
        send_item(tdma_st_pkg::CMD_JOIN, 8'd128, 32'd40);
        send_item(tdma_st_pkg::CMD_REFRESH, 8'd128, 32'd41);
        send_item(tdma_st_pkg::CMD_SWEEP, 8'd255, 32'h8000_0000);
        send_item(tdma_st_pkg::CMD_SWEEP, 8'd1, 32'h8000_0001);

        // Random phases, each with its own timeout and amount of sender idling.
        for (int p = 0; p < PHASES; p++)
        begin
            write_timeout(tdma_st_pkg::TIMEOUT_W'(tmo_set[p]));
            idle_pct = idle_set[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(149) == 0)
                    drain();
                random_item(tmo_set[p]);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (table_model.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
